// ----- rtl/chs_pkg.sv -----
// Shared types, constants and command/status structures for the chained hash set.
package chs_pkg;

    localparam int BUCKETS   = 1024;
    localparam int NODES     = 1024;
    localparam int KEY_BITS  = 32;
    localparam int SIZE_W    = 11;
    localparam int CNT_W     = 11;
    localparam int STATUS_W  = 3;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int NODE_W    = $clog2(NODES);
    localparam int USED_W    = $clog2(NODES + 1);
    localparam int LEN_W     = $clog2(NODES + 1);
    localparam int BIT_W     = $clog2(KEY_BITS);
    localparam int SIZE_RESET = 1021;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic ACT_SEARCH = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_BREAD,
        S_BLOAD,
        S_WALK,
        S_NCMP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic div_step;
        logic bload;
        logic ncmp;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic chain_more;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/chs_ctrl.sv -----
// Controller state machine that sequences hashing, chain walk and update.
module chs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  chs_pkg::stat_t  stat,
    output chs_pkg::cmd_t   cmd
);

    chs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chs_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            chs_pkg::S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = chs_pkg::S_IDLE;
                end
            end
            chs_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = chs_pkg::S_DIV;
                end
            end
            chs_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = chs_pkg::S_BREAD;
                end
            end
            chs_pkg::S_BREAD: begin
                state_next = chs_pkg::S_BLOAD;
            end
            chs_pkg::S_BLOAD: begin
                cmd.bload  = 1'b1;
                state_next = chs_pkg::S_WALK;
            end
            chs_pkg::S_WALK: begin
                // The node memory is read at the current node during this cycle.
                if (stat.chain_more) begin
                    state_next = chs_pkg::S_NCMP;
                end else begin
                    state_next = chs_pkg::S_FIN;
                end
            end
            chs_pkg::S_NCMP: begin
                cmd.ncmp   = 1'b1;
                state_next = chs_pkg::S_WALK;
            end
            chs_pkg::S_FIN: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = chs_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = chs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/chs_datapath.sv -----
// Datapath: modulo unit, bucket and node memories, chain walk and result register.
module chs_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  chs_pkg::cmd_t                  cmd,
    output chs_pkg::stat_t                 stat,
    input  logic [chs_pkg::SIZE_W-1:0]     size,
    input  logic                           in_action,
    input  logic [chs_pkg::KEY_BITS-1:0]   in_key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [chs_pkg::STATUS_W-1:0]   out_status,
    output logic [chs_pkg::CNT_W-1:0]      out_count
);

    localparam int BENT_W = chs_pkg::NODE_W + chs_pkg::LEN_W;
    localparam int NENT_W = chs_pkg::KEY_BITS + chs_pkg::NODE_W;

    logic [BENT_W-1:0] bmem [chs_pkg::BUCKETS];
    logic [NENT_W-1:0] nmem [chs_pkg::NODES];

    logic                          act_reg;
    logic [chs_pkg::KEY_BITS-1:0]  key_reg, ksh_reg;
    logic [chs_pkg::BIT_W-1:0]     bit_reg;
    logic [chs_pkg::BKT_W-1:0]     rem_reg, clr_reg;
    logic [BENT_W-1:0]             brd_reg;
    logic [NENT_W-1:0]             nrd_reg;
    logic [chs_pkg::NODE_W-1:0]    head_reg, at_reg;
    logic [chs_pkg::LEN_W-1:0]     len_reg, left_reg;
    logic [chs_pkg::CNT_W-1:0]     cnt_reg;
    logic                          hit_reg;
    logic [chs_pkg::USED_W-1:0]    used_reg;
    logic                          oval_reg;
    logic [chs_pkg::STATUS_W-1:0]  ost_reg;
    logic [chs_pkg::CNT_W-1:0]     ocnt_reg;

    logic [chs_pkg::SIZE_W-1:0]    rsh;
    logic [chs_pkg::SIZE_W-1:0]    rsub;
    logic                          full;
    logic                          do_insert;
    logic [chs_pkg::STATUS_W-1:0]  status;
    logic [chs_pkg::NODE_W-1:0]    new_link;

    // One restoring step of key mod size; the remainder always stays below size.
    always_comb begin
        rsh  = {rem_reg, ksh_reg[chs_pkg::KEY_BITS-1]};
        rsub = rsh - size;
    end

    assign full      = (used_reg >= chs_pkg::USED_W'(chs_pkg::NODES));
    assign do_insert = (act_reg == chs_pkg::ACT_INSERT) && !hit_reg && !full;
    assign new_link  = (len_reg != '0) ? head_reg : '0;

    always_comb begin
        if (act_reg == chs_pkg::ACT_SEARCH) begin
            status = hit_reg ? chs_pkg::ST_FOUND : chs_pkg::ST_MISSING;
        end else if (hit_reg) begin
            status = chs_pkg::ST_DUPLICATE;
        end else if (full) begin
            status = chs_pkg::ST_FULL;
        end else begin
            status = chs_pkg::ST_INSERTED;
        end
    end

    always_ff @(posedge aclk) begin
        brd_reg <= bmem[rem_reg];
        nrd_reg <= nmem[at_reg];
        if (cmd.clr_wr) begin
            bmem[clr_reg] <= '0;
        end else if (cmd.commit && do_insert) begin
            bmem[rem_reg] <= {used_reg[chs_pkg::NODE_W-1:0], len_reg + 1'b1};
        end
        if (cmd.commit && do_insert) begin
            nmem[used_reg[chs_pkg::NODE_W-1:0]] <= {key_reg, new_link};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= in_action;
            key_reg <= in_key;
            ksh_reg <= in_key;
            rem_reg <= '0;
            hit_reg <= 1'b0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            ksh_reg <= ksh_reg << 1;
            rem_reg <= (rsh >= size) ? rsub[chs_pkg::BKT_W-1:0] : rsh[chs_pkg::BKT_W-1:0];
        end
        if (cmd.bload) begin
            head_reg <= brd_reg[BENT_W-1:chs_pkg::LEN_W];
            len_reg  <= brd_reg[chs_pkg::LEN_W-1:0];
            at_reg   <= brd_reg[BENT_W-1:chs_pkg::LEN_W];
            left_reg <= brd_reg[chs_pkg::LEN_W-1:0];
        end
        if (cmd.ncmp) begin
            cnt_reg  <= cnt_reg + 1'b1;
            left_reg <= left_reg - 1'b1;
            if (nrd_reg[NENT_W-1:chs_pkg::NODE_W] == key_reg) begin
                hit_reg <= 1'b1;
            end else begin
                at_reg <= nrd_reg[chs_pkg::NODE_W-1:0];
            end
        end
        if (cmd.commit) begin
            ost_reg  <= status;
            ocnt_reg <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg  <= '0;
            clr_reg  <= '0;
            used_reg <= '0;
            oval_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                bit_reg <= '0;
            end else if (cmd.div_step) begin
                bit_reg <= bit_reg + 1'b1;
            end
            if (cmd.clr_wr) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.commit && do_insert) begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.commit) begin
                oval_reg <= 1'b1;
            end else if (out_ready) begin
                oval_reg <= 1'b0;
            end
        end
    end

    assign stat.clr_last   = (clr_reg == chs_pkg::BKT_W'(chs_pkg::BUCKETS - 1));
    assign stat.div_last   = (bit_reg == chs_pkg::BIT_W'(chs_pkg::KEY_BITS - 1));
    assign stat.chain_more = (left_reg != '0) && !hit_reg;
    assign stat.out_free   = !oval_reg || out_ready;

    assign out_valid  = oval_reg;
    assign out_status = ost_reg;
    assign out_count  = ocnt_reg;

endmodule

// ----- rtl/chained_hash_set.sv -----
// Top level of the chained hash set: stream channels, register port, controller and datapath.
//
// Each input word asks to search for (tuser 0) or insert (tuser 1) the 32-bit key in
// s_tdata. Every accepted word yields exactly one result word on the m_ channel with a
// status (found, not found, inserted, duplicate skipped, pool full) and the number of
// chain nodes compared. The bucket is the key modulo table_size, written over the
// register port (paddr[2] low); the user must write it only while the block is idle, which
// the block does not enforce. Values below 2 act as 2 and above 1024 as 1024.
// One item passes through the bit-serial modulo unit and the bucket memory read, then
// a node memory read and compare for each chain node visited, and a finishing step; the
// next word is accepted only once the result is registered.
// A result waits in an output register while the receiver stalls; the block already
// accepts the next word and stops only before writing a new result over one not taken.
// After reset a clearing pass empties all 1024 bucket table entries; s_tready stays
// low during it. The table size returns to 1021 and the node pool is emptied.
module chained_hash_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] status, [13:3] comparisons, [15:14] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    chs_pkg::cmd_t  cmd;
    chs_pkg::stat_t stat;

    logic [chs_pkg::SIZE_W-1:0]   size_reg;
    logic [chs_pkg::SIZE_W-1:0]   size_eff;
    logic [chs_pkg::STATUS_W-1:0] out_status;
    logic [chs_pkg::CNT_W-1:0]    out_count;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= chs_pkg::SIZE_W'(chs_pkg::SIZE_RESET);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            size_reg <= pwdata[chs_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32 - chs_pkg::SIZE_W){1'b0}}, size_reg} : '0;

    always_comb begin
        if (size_reg < chs_pkg::SIZE_W'(2)) begin
            size_eff = chs_pkg::SIZE_W'(2);
        end else if (size_reg > chs_pkg::SIZE_W'(chs_pkg::BUCKETS)) begin
            size_eff = chs_pkg::SIZE_W'(chs_pkg::BUCKETS);
        end else begin
            size_eff = size_reg;
        end
    end

    chs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chs_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .size       (size_eff),
        .in_action  (s_tuser),
        .in_key     (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_tdata = {2'b00, out_count, out_status};

endmodule
